// File: rtl/iirdf1_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package iirdf1_pkg;

  // Filter length (feedforward taps; feedback uses TAPS-1 taps)
  localparam int TAPS_DEFAULT = 8;

  localparam int SMP_W     = 16;
  localparam int COEF_W    = 32;
  localparam int CFG_W     = 64;
  localparam int NUM_CFG   = 8;
  localparam int CFG_IDX_W = 3;
  localparam int FRAC_W    = 28;
  localparam int PROD_W    = COEF_W + SMP_W;
  // 15 products of at most 2^46 in magnitude fit comfortably
  localparam int ACC_W     = PROD_W + 4;
  localparam int YFULL_W   = ACC_W - FRAC_W;

  // Register indices
  localparam logic [CFG_IDX_W-1:0] CFG_B01 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_B23 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_B45 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_B67 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_A12 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_A34 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_A56 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_A7  = 3'd7;

  // b0 = 1.0 in Q4.28, all else zero
  localparam logic [CFG_W-1:0] CFG_RESET [NUM_CFG] = '{
    64'h0000_0000_1000_0000, 64'h0, 64'h0, 64'h0,
    64'h0, 64'h0, 64'h0, 64'h0
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_FIN
  } iirdf1_state_e;

endpackage

`default_nettype wire

// File: rtl/iirdf1_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface iirdf1_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [iirdf1_pkg::SMP_W-1:0] sample_in;
  logic                                last_in_buffer;

  modport source (output valid, output sample_in, output last_in_buffer, input ready);
  modport sink   (input valid, input sample_in, input last_in_buffer, output ready);
endinterface

interface iirdf1_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [iirdf1_pkg::SMP_W-1:0] sample_out;
  logic                                saturated;

  modport source (output valid, output sample_out, output saturated, input ready);
  modport sink   (input valid, input sample_out, input saturated, output ready);
endinterface

`default_nettype wire

// File: rtl/iir_direct_form1_filter_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Direct form I IIR filter on signed 16-bit samples, one output per input.
// y[n] = sum b[k]*x[n-k] - sum a[l]*y[n-l], coefficients signed Q4.28, packed
// two per 64-bit register (reg 7 holds a7 alone). A lower order is set by
// zeroing unused taps. The exact sum is rounded half up, floored and clipped
// to int16; saturated flags a clip. Feedback uses the clipped outputs.
// Both histories clear after a sample transferred with last_in_buffer set.
// One shared 32x16 multiplier and an accumulator run the 2*TAPS-1 products
// in sequence, pipelined one product per cycle. After the input transfer the
// sequencer steps through MAC, DRAIN and FIN, where the result is written to
// the output register, and only then returns to IDLE to take the next sample,
// so a new sample is not accepted while one is in progress. A finished
// result is held in the output register, so the next sample may be
// transferred while it waits; the sequencer only stalls at the end of a
// sample if the previous result has still not been taken.
// Coefficient writes are to be made while the filter is idle.

module iir_direct_form1_filter_unit #(
  parameter int TAPS = iirdf1_pkg::TAPS_DEFAULT
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [iirdf1_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [iirdf1_pkg::CFG_W-1:0]      cfg_wdata_i,
  iirdf1_in_if.sink                              in_i,
  iirdf1_out_if.source                           out_o
);

  import iirdf1_pkg::*;

  localparam int HIST = (TAPS > 1) ? TAPS - 1 : 1;
  localparam int TW   = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int HW   = (HIST > 1) ? $clog2(HIST) : 1;
  localparam logic [TW-1:0] TAP_LAST = TW'(TAPS - 1);

  localparam logic signed [ACC_W-1:0]   HALF_LSB = ACC_W'(1) << (FRAC_W - 1);
  localparam logic signed [YFULL_W-1:0] Y_MAX    = YFULL_W'(32767);
  localparam logic signed [YFULL_W-1:0] Y_MIN    = -YFULL_W'(32768);

  // ---------------------------------------------------------------------
  // Coefficient registers
  // ---------------------------------------------------------------------
  logic [CFG_W-1:0] cfg_q [NUM_CFG];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CFG; i++) begin
        cfg_q[i] <= CFG_RESET[i];
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_A7) begin
        cfg_q[cfg_idx_i] <= {{(CFG_W-COEF_W){1'b0}}, cfg_wdata_i[COEF_W-1:0]};
      end else begin
        cfg_q[cfg_idx_i] <= cfg_wdata_i;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer and datapath state
  // ---------------------------------------------------------------------
  iirdf1_state_e state_q, state_d;

  logic [TW-1:0]              tap_q, tap_d;
  logic                       fb_q, fb_d;       // feedback half of the tap
  logic signed [SMP_W-1:0]    x_q, x_d;
  logic                       last_q, last_d;
  logic signed [PROD_W-1:0]   prod_q, prod_d;
  logic                       prod_neg_q, prod_neg_d;
  logic                       prod_vld_q, prod_vld_d;
  logic signed [ACC_W-1:0]    acc_q, acc_d;

  logic signed [SMP_W-1:0]    xh_q [HIST];
  logic signed [SMP_W-1:0]    yh_q [HIST];

  logic signed [SMP_W-1:0]    out_smp_q, out_smp_d;
  logic                       out_sat_q, out_sat_d;
  logic                       out_vld_q, out_vld_d;

  logic in_fire;
  logic last_issue;
  logic out_free;
  logic fin_fire;

  assign in_fire    = in_i.valid && in_i.ready;
  assign last_issue = (tap_q == TAP_LAST) && (fb_q || (TAPS == 1));
  assign out_free   = !out_vld_q || out_o.ready;
  assign fin_fire   = (state_q == ST_FIN) && out_free;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_fire) state_d = ST_MAC;
      ST_MAC:   if (last_issue) state_d = ST_DRAIN;
      ST_DRAIN: state_d = ST_FIN;
      ST_FIN:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Operand selection for the shared multiplier
  logic [2:0]              tap3, tap3_m1;
  logic [CFG_IDX_W-1:0]    coef_reg;
  logic                    coef_hi;
  logic signed [COEF_W-1:0] coef_sel;
  logic [HW-1:0]           hidx;
  logic signed [SMP_W-1:0] data_sel;

  always_comb begin
    tap3    = 3'(tap_q);
    tap3_m1 = tap3 - 3'd1;
    hidx    = HW'(tap_q - TW'(1));
    if (!fb_q) begin
      // b[k]: reg k/2, half k%2
      coef_reg = {1'b0, tap3[2:1]};
      coef_hi  = tap3[0];
      data_sel = (tap_q == '0) ? x_q : xh_q[hidx];
    end else begin
      // a[k]: reg 4 + (k-1)/2, half (k-1)%2
      coef_reg = {1'b1, tap3_m1[2:1]};
      coef_hi  = tap3_m1[0];
      data_sel = yh_q[hidx];
    end
    coef_sel = coef_hi ? cfg_q[coef_reg][CFG_W-1:COEF_W] : cfg_q[coef_reg][COEF_W-1:0];
  end

  // Rounding and clipping
  logic signed [ACC_W-1:0]   acc_rnd;
  logic signed [YFULL_W-1:0] y_full;

  assign acc_rnd = acc_q + HALF_LSB;
  assign y_full  = acc_rnd[ACC_W-1:FRAC_W];

  // Datapath and output controls
  always_comb begin
    tap_d      = tap_q;
    fb_d       = fb_q;
    x_d        = x_q;
    last_d     = last_q;
    prod_d     = prod_q;
    prod_neg_d = prod_neg_q;
    prod_vld_d = prod_vld_q;
    acc_d      = acc_q;
    out_smp_d  = out_smp_q;
    out_sat_d  = out_sat_q;
    out_vld_d  = out_vld_q && !out_o.ready;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          x_d        = in_i.sample_in;
          last_d     = in_i.last_in_buffer;
          tap_d      = '0;
          fb_d       = 1'b0;
          acc_d      = '0;
          prod_vld_d = 1'b0;
        end
      end
      ST_MAC: begin
        prod_d     = coef_sel * data_sel;
        prod_neg_d = fb_q;
        prod_vld_d = 1'b1;
        if (prod_vld_q) begin
          acc_d = prod_neg_q ? acc_q - ACC_W'(prod_q) : acc_q + ACC_W'(prod_q);
        end
        if (!fb_q && (tap_q != '0)) begin
          fb_d = 1'b1;
        end else begin
          fb_d  = 1'b0;
          tap_d = tap_q + TW'(1);
        end
      end
      ST_DRAIN: begin
        if (prod_vld_q) begin
          acc_d = prod_neg_q ? acc_q - ACC_W'(prod_q) : acc_q + ACC_W'(prod_q);
        end
        prod_vld_d = 1'b0;
      end
      ST_FIN: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          if (y_full > Y_MAX) begin
            out_smp_d = SMP_W'(32767);
            out_sat_d = 1'b1;
          end else if (y_full < Y_MIN) begin
            out_smp_d = -SMP_W'(32768);
            out_sat_d = 1'b1;
          end else begin
            out_smp_d = y_full[SMP_W-1:0];
            out_sat_d = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      tap_q      <= '0;
      fb_q       <= 1'b0;
      prod_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      tap_q      <= tap_d;
      fb_q       <= fb_d;
      prod_vld_q <= prod_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    last_q     <= last_d;
    prod_q     <= prod_d;
    prod_neg_q <= prod_neg_d;
    acc_q      <= acc_d;
    out_smp_q  <= out_smp_d;
    out_sat_q  <= out_sat_d;
  end

  // History lines: shift in the finished sample pair, clear at end of buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HIST; i++) begin
        xh_q[i] <= '0;
        yh_q[i] <= '0;
      end
    end else if (fin_fire) begin
      if (last_q) begin
        for (int i = 0; i < HIST; i++) begin
          xh_q[i] <= '0;
          yh_q[i] <= '0;
        end
      end else begin
        for (int i = HIST - 1; i > 0; i--) begin
          xh_q[i] <= xh_q[i-1];
          yh_q[i] <= yh_q[i-1];
        end
        xh_q[0] <= x_q;
        yh_q[0] <= out_smp_d;
      end
    end
  end

  assign in_i.ready       = (state_q == ST_IDLE);
  assign out_o.valid      = out_vld_q;
  assign out_o.sample_out = out_smp_q;
  assign out_o.saturated  = out_sat_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_start_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_MAC) && !prod_vld_q && (tap_q == '0))
    else $error("sample transfer did not start a clean MAC sequence");

  a_fin_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) && out_vld_q && !out_o.ready |=> (state_q == ST_FIN))
    else $error("result overwritten while output register still full");

  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> ($past(state_q) == ST_FIN))
    else $error("output became valid outside the finish step");

  a_sat_clipped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_sat_q |-> (out_smp_q == SMP_W'(32767)) ||
                               (out_smp_q == -SMP_W'(32768)))
    else $error("saturated flag set on an unclipped value");

endmodule

`default_nettype wire

// File: tb/iir_direct_form1_filter_unit_tb.sv
`timescale 1ns / 1ps

module iir_direct_form1_filter_unit_tb;
  import iirdf1_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int TAPS           = TAPS_DEFAULT;
  // settle time after draining; covers one full sample sequence with margin
  localparam int SETTLE_CYCLES  = 2 * TAPS + 6;
  // long receiver hold-off so the block backs up and stalls its input
  localparam int HOLD_CYCLES    = 400;
  localparam int WAIT_MAX       = 18;
  // watchdog limit, set well above the length of the slowest run
  localparam int TIMEOUT_CYCLES = 300000;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample;
    logic                    last;
  } sample_item_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample;
    logic                    sat;
  } filt_result_t;

  typedef enum {
    COEF_PASS,
    COEF_MILD,
    COEF_WILD,
    COEF_MAX,
    COEF_MIN,
    COEF_ZERO
  } coef_mode_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;

  iirdf1_in_if  in_if ();
  iirdf1_out_if out_if ();

  iir_direct_form1_filter_unit #(
    .TAPS (TAPS)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shared state between stimulus, driver, receiver and checker
  // ---------------------------------------------------------------------------
  sample_item_t pending_samples[$];   // samples still to be offered
  filt_result_t expected_outputs[$];  // predicted results, oldest first
  int           fail_cnt = 0;

  bit in_taken;     // an input transfer happened at the last rising edge
  bit out_taken;    // an output transfer happened at the last rising edge
  bit src_idle;     // sender inserts random gaps in this phase
  bit snk_idle;     // receiver inserts random stalls in this phase
  bit squeeze_req;  // ask the receiver for one long hold-off
  int src_gap;
  int snk_stall;
  int snk_hold_left;

  sample_item_t next_item;
  filt_result_t want;

  // coefficient sets for the next programming pass (a_set[0] unused)
  logic [COEF_W-1:0] b_set [8];
  logic [COEF_W-1:0] a_set [8];

  // ---------------------------------------------------------------------------
  // Predictor: own copy of the registers and both histories
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0]        cfg_shadow [NUM_CFG];
  logic signed [SMP_W-1:0] x_hist [TAPS-1];
  logic signed [SMP_W-1:0] y_hist [TAPS-1];

  function automatic longint coef_q428(input int reg_idx, input int hi);
    logic [CFG_W-1:0] w;
    w = cfg_shadow[reg_idx];
    return hi != 0 ? longint'($signed(w[63:32])) : longint'($signed(w[31:0]));
  endfunction

  function automatic void clear_hist();
    for (int k = 0; k < TAPS - 1; k++) begin
      x_hist[k] = '0;
      y_hist[k] = '0;
    end
  endfunction

  // One output per sample; updates the histories as the block does.
  function automatic filt_result_t iir_predict(input logic signed [SMP_W-1:0] x,
                                               input logic last);
    longint       acc;
    longint       y;
    filt_result_t res;
    acc = coef_q428(0, 0) * longint'(x);
    for (int k = 1; k < TAPS; k++) begin
      acc += coef_q428(k / 2, k % 2) * longint'(x_hist[k-1]);
      acc -= coef_q428(int'(CFG_A12) + (k - 1) / 2, (k - 1) % 2) * longint'(y_hist[k-1]);
    end
    // half-LSB bias then floor, i.e. round half up
    acc += longint'(1) <<< (FRAC_W - 1);
    y = acc >>> FRAC_W;
    res.sat = 1'b0;
    if (y > 32767) begin
      y = 32767;
      res.sat = 1'b1;
    end else if (y < -32768) begin
      y = -32768;
      res.sat = 1'b1;
    end
    res.sample = y[SMP_W-1:0];
    for (int k = TAPS - 2; k > 0; k--) begin
      x_hist[k] = x_hist[k-1];
      y_hist[k] = y_hist[k-1];
    end
    if (TAPS > 1) begin
      x_hist[0] = x;
      y_hist[0] = res.sample;
    end
    // end of buffer: fresh start for the next sample
    if (last) clear_hist();
    return res;
  endfunction

  function automatic int draw_wait(input bit enabled);
    return enabled ? int'($urandom_range(0, WAIT_MAX)) : 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: predict on every accepted transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready) begin
        expected_outputs.push_back(iir_predict(in_if.sample_in, in_if.last_in_buffer));
      end
    end
  end

  // Driver: drives at the falling edge, holds an item until it is transferred,
  // then waits a random gap before offering the next one.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) src_gap = draw_wait(src_idle);
      if (!in_if.valid || in_taken) begin
        if (src_gap > 0) begin
          src_gap--;
          in_if.valid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          next_item = pending_samples.pop_front();
          in_if.sample_in      <= next_item.sample;
          in_if.last_in_buffer <= next_item.last;
          in_if.valid          <= 1'b1;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output side: receiver stalls and the checker
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken) snk_stall = draw_wait(snk_idle);
      if (squeeze_req) begin
        snk_hold_left = HOLD_CYCLES;
        squeeze_req   = 1'b0;
      end
      if (snk_hold_left > 0) begin
        snk_hold_left--;
        out_if.ready <= 1'b0;
      end else if (snk_stall > 0) begin
        snk_stall--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_taken <= 1'b0;
    end else begin
      out_taken <= out_if.valid && out_if.ready;
      if (out_if.valid && out_if.ready) begin
        if (expected_outputs.size() == 0) begin
          $display("%0t: unexpected result sample_out=%0d saturated=%0b", $time,
                   out_if.sample_out, out_if.saturated);
          fail_cnt++;
        end else begin
          want = expected_outputs.pop_front();
          if (out_if.sample_out !== want.sample) begin
            $display("%0t: sample_out mismatch: expected %0d, actual %0d", $time,
                     want.sample, out_if.sample_out);
            fail_cnt++;
          end
          if (out_if.saturated !== want.sat) begin
            $display("%0t: saturated mismatch: expected %0b, actual %0b", $time,
                     want.sat, out_if.saturated);
            fail_cnt++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Register write at the falling edge; the shadow follows, masked as the
  // block masks it (only the low 32 bits of the a7 register are kept).
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_A7) cfg_shadow[idx] = {32'h0, data[31:0]};
    else cfg_shadow[idx] = data;
  endtask

  task automatic program_filter();
    logic [31:0] junk;
    junk = $urandom();
    cfg_write(CFG_B01, {b_set[1], b_set[0]});
    cfg_write(CFG_B23, {b_set[3], b_set[2]});
    cfg_write(CFG_B45, {b_set[5], b_set[4]});
    cfg_write(CFG_B67, {b_set[7], b_set[6]});
    cfg_write(CFG_A12, {a_set[2], a_set[1]});
    cfg_write(CFG_A34, {a_set[4], a_set[3]});
    cfg_write(CFG_A56, {a_set[6], a_set[5]});
    // upper half of the a7 write is junk that must be dropped
    cfg_write(CFG_A7, {junk, a_set[7]});
  endtask

  function automatic logic [COEF_W-1:0] rand_coef(input int span);
    int v;
    v = int'($urandom_range(0, 2 * span)) - span;
    return v;
  endfunction

  function automatic logic [COEF_W-1:0] gen_coef(input coef_mode_e mode, input int span);
    case (mode)
      COEF_MILD: return rand_coef(span);
      COEF_WILD: return $urandom();
      COEF_MAX:  return 32'h7FFF_FFFF;
      COEF_MIN:  return 32'h8000_0000;
      default:   return '0;
    endcase
  endfunction

  // Taps at or above the chosen order are zeroed to give a shorter filter.
  task automatic pick_coefs(input coef_mode_e mode, input int order);
    for (int k = 0; k < 8; k++) begin
      b_set[k] = (k < order) ? gen_coef(mode, 1 << 26) : '0;
      a_set[k] = (k > 0 && k < order) ? gen_coef(mode, 1 << 24) : '0;
    end
    if (mode == COEF_PASS) b_set[0] = 32'h1000_0000;
  endtask

  function automatic logic signed [SMP_W-1:0] rand_sample();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'(int'($urandom_range(0, 64)) - 32);
      default: return r[15:0];
    endcase
  endfunction

  task automatic push_sample(input logic signed [SMP_W-1:0] s, input logic last);
    sample_item_t it;
    it.sample = s;
    it.last   = last;
    pending_samples.push_back(it);
  endtask

  // Mostly whole buffers closed by a last flag; now and then a lone sample
  // with a random flag, so buffers also get cut short or run on.
  task automatic queue_buffers(input int n);
    int cnt;
    int len;
    cnt = 0;
    while (cnt < n) begin
      if ($urandom_range(0, 9) == 0) begin
        push_sample(rand_sample(), 1'($urandom_range(0, 1)));
        cnt++;
      end else begin
        len = $urandom_range(1, 40);
        if (len > n - cnt) len = n - cnt;
        for (int i = 0; i < len; i++) push_sample(rand_sample(), i == len - 1);
        cnt += len;
      end
    end
  endtask

  // Idle means: nothing queued, nothing offered, nothing outstanding.
  task automatic wait_drained();
    while (pending_samples.size() != 0 || in_if.valid || expected_outputs.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(input coef_mode_e mode, input int order, input bit gaps,
                           input bit stalls, input bit squeeze, input int n);
    pick_coefs(mode, order);
    program_filter();
    src_idle = gaps;
    snk_idle = stalls;
    if (squeeze) squeeze_req = 1'b1;
    queue_buffers(n);
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_idx_i            = CFG_B01;
    cfg_wdata_i          = '0;
    in_if.valid          = 1'b0;
    in_if.sample_in      = '0;
    in_if.last_in_buffer = 1'b0;
    out_if.ready         = 1'b0;
    src_idle             = 1'b1;
    snk_idle             = 1'b1;
    squeeze_req          = 1'b0;
    src_gap              = 0;
    snk_stall            = 0;
    snk_hold_left        = 0;
    for (int r = 0; r < NUM_CFG; r++) cfg_shadow[r] = CFG_RESET[r];
    clear_hist();

    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset coefficients give a straight pass-through
    push_sample(16'sh7FFF, 1'b0);
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sh0000, 1'b0);
    push_sample(-16'sd1, 1'b0);
    push_sample(16'sd1, 1'b1);
    wait_drained();

    // b0 near +8: clip high and low
    pick_coefs(COEF_ZERO, 8);
    b_set[0] = 32'h7FFF_FFFF;
    program_filter();
    push_sample(16'sh7FFF, 1'b0);
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sh0000, 1'b0);
    push_sample(16'sd1, 1'b1);
    wait_drained();

    // b0 = -8: the sign flips the clip direction
    b_set[0] = 32'h8000_0000;
    program_filter();
    push_sample(16'sh7FFF, 1'b0);
    push_sample(16'sh8000, 1'b1);
    wait_drained();

    // b0 = 0.5: ties round upwards, on both signs
    b_set[0] = 32'h0800_0000;
    program_filter();
    push_sample(16'sd1, 1'b0);
    push_sample(-16'sd1, 1'b0);
    push_sample(16'sd3, 1'b0);
    push_sample(-16'sd3, 1'b1);
    wait_drained();

    // impulse through feedback and the deepest taps, then a sample after the
    // buffer end to show the histories were cleared
    b_set[0] = 32'h1000_0000;
    b_set[1] = 32'h0800_0000;
    b_set[7] = 32'h0400_0000;
    a_set[1] = 32'hF800_0000;
    a_set[7] = 32'h0400_0000;
    program_filter();
    push_sample(16'sd10000, 1'b0);
    for (int i = 0; i < 7; i++) push_sample(16'sd0, 1'b0);
    push_sample(16'sd0, 1'b1);
    push_sample(16'sd0, 1'b0);
    wait_drained();

    // random part over several coefficient settings and idling patterns
    run_phase(COEF_MILD, 8, 1'b1, 1'b1, 1'b0, 105);
    run_phase(COEF_MILD, $urandom_range(1, 4), 1'b0, 1'b0, 1'b0, 105);
    // receiver holds off while the sender keeps offering: block backs up
    run_phase(COEF_MILD, 8, 1'b0, 1'b1, 1'b1, 105);
    run_phase(COEF_WILD, 8, 1'b1, 1'b1, 1'b0, 100);
    run_phase(COEF_MAX, 8, 1'b1, 1'b0, 1'b0, 60);
    run_phase(COEF_MIN, 8, 1'b0, 1'b1, 1'b0, 60);
    run_phase(COEF_ZERO, 8, 1'b1, 1'b1, 1'b0, 20);
    run_phase(COEF_MILD, $urandom_range(5, 8), 1'b1, 1'b1, 1'b0, 100);

    if (fail_cnt == 0 && expected_outputs.size() == 0) begin
      $display("** iir_direct_form1_filter_unit: PASSED **");
    end else begin
      $display("** iir_direct_form1_filter_unit: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("timeout, %0d results outstanding", expected_outputs.size());
    $display("** iir_direct_form1_filter_unit: FAILED **");
    $finish;
  end

endmodule
